// ===== hdl/cas_pkg.sv =====
// Shared types, widths and constants for the CIGAR alignment scorer.
// No dependencies; imported by cas_ctrl, cas_dp, cigar_alignment_score and the testbench.
`default_nettype none

package cas_pkg;

    // Field widths
    localparam int OP_W     = 3;
    localparam int LEN_W    = 28;
    localparam int POS_W    = 31;
    localparam int NM_W     = 16;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int SUM_W    = 32;
    localparam int RUN_W    = 16;

    // Run counters stop at this value
    localparam logic [RUN_W-1:0] MAX_OPS = 16'hFFFF;
    localparam logic [SUM_W-1:0] SAT32   = 32'hFFFF_FFFF;

    // Score arithmetic widths
    localparam int N_W     = 44;            // signed raw score
    localparam int NUM_W   = 54;            // signed 1000*n + 499*a
    localparam int MAG_W   = NUM_W - 1;     // magnitude of the dividend
    localparam int DEN_W   = 18;            // 1000*a
    localparam int DIV_CNT_W = $clog2(MAG_W);

    typedef enum logic [OP_W-1:0] {
        OP_M = 3'd0,
        OP_I = 3'd1,
        OP_D = 3'd2,
        OP_N = 3'd3,
        OP_S = 3'd4,
        OP_H = 3'd5
    } op_code_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_EXT  = 8'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic acc_en;     // accumulate one op
        logic prep_en;    // start, sums, indel, runs
        logic mul_en;     // products and saturated side outputs
        logic sum_en;     // raw score
        logic scale_en;   // numerator
        logic abs_en;     // sign split, divider load
        logic div_step;   // one quotient bit
        logic fix_en;     // floor correction and saturation
        logic load_out;   // move result to output, clear accumulators
    } cas_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/cigar_alignment_score.sv =====
// Top level of the CIGAR alignment scorer: joins the sequencer and the datapath.
// Depends on cas_pkg, cas_ctrl and cas_dp.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     op_code, op_length, ref_position, nm_tag, last_op
// out      output     out_valid / out_ready   ref_start, ref_end, edit_distance, score,
//                                             query_length, hard_clipped
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A non-final op is accumulated in the idle state: one transaction per clock while accumulating.
// After the final op of an alignment the sequencer steps through PREP, MUL, SUM, SCALE,
// ABS, the restoring divider loop (DIV, one quotient bit a clock), FIX and WAIT before its
// result reaches the output register. The input stays closed throughout.
// A result waiting on out_ready does not block accumulation of the next alignment;
// only the result of the next final op waits in the sequencer, input closed, until
// the output register drains.
// Reset restores the register defaults and clears the accumulators; cfg_ready is
// always high.
`default_nettype none

module cigar_alignment_score
    import cas_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // op input
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [OP_W-1:0]        op_code,
    input  wire logic [LEN_W-1:0]       op_length,
    input  wire logic [POS_W-1:0]       ref_position,
    input  wire logic [NM_W-1:0]        nm_tag,
    input  wire logic                   last_op,
    // result output
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [POS_W-1:0]            ref_start,
    output logic [SUM_W-1:0]            ref_end,
    output logic [SUM_W-1:0]            edit_distance,
    output logic signed [SUM_W-1:0]     score,
    output logic [SUM_W-1:0]            query_length,
    output logic                        hard_clipped,
    // register writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    cas_cmd_t cmd;

    // The user must write registers only while idle; unchecked, so accept every transaction.
    assign cfg_ready = 1'b1;

    cas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_op   (last_op),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    cas_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op_code       (op_code),
        .op_length     (op_length),
        .ref_position  (ref_position),
        .nm_tag        (nm_tag),
        .ref_start     (ref_start),
        .ref_end       (ref_end),
        .edit_distance (edit_distance),
        .score         (score),
        .query_length  (query_length),
        .hard_clipped  (hard_clipped)
    );

endmodule

`default_nettype wire

// ===== hdl/cas_ctrl.sv =====
// Sequencer of the CIGAR alignment scorer: accumulate, score steps, divider loop.
// Depends on cas_pkg.
`default_nettype none

module cas_ctrl
    import cas_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     last_op,
    input  wire logic     out_ready,
    output logic          in_ready,
    output logic          out_valid,
    output cas_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_SUM,
        S_SCALE,
        S_ABS,
        S_DIV,
        S_FIX,
        S_WAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.acc_en = 1'b1;
                    if (last_op)
                        state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep_en = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = S_ABS;
            end
            S_ABS:
            begin
                cmd.abs_en = 1'b1;
                cnt_next   = DIV_CNT_W'(MAG_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_FIX;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_FIX:
            begin
                cmd.fix_en = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/cas_dp.sv =====
// Datapath of the CIGAR alignment scorer: config registers, accumulators,
// score arithmetic, restoring divider and output registers. Depends on cas_pkg.
`default_nettype none

module cas_dp
    import cas_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cas_cmd_t               cmd,
    input  wire logic                   cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic [OP_W-1:0]        op_code,
    input  wire logic [LEN_W-1:0]       op_length,
    input  wire logic [POS_W-1:0]       ref_position,
    input  wire logic [NM_W-1:0]        nm_tag,
    output logic [POS_W-1:0]            ref_start,
    output logic [SUM_W-1:0]            ref_end,
    output logic [SUM_W-1:0]            edit_distance,
    output logic signed [SUM_W-1:0]     score,
    output logic [SUM_W-1:0]            query_length,
    output logic                        hard_clipped
);

    // Configuration
    logic [CFG_W-1:0] a_cfg_reg, b_cfg_reg, o_cfg_reg, e_cfg_reg;

    // Accumulators
    logic [SUM_W-1:0] match_reg, ins_reg, del_reg, skip_reg, clip_reg;
    logic [RUN_W-1:0] ins_runs_reg, del_runs_reg;
    logic             hard_reg;
    logic [POS_W-1:0] pos_reg;
    logic [NM_W-1:0]  nm_reg;

    // Score pipeline
    logic [POS_W-1:0]        start_reg;
    logic [SUM_W+1:0]        mds_reg, qsum_reg;
    logic [SUM_W:0]          indel_reg;
    logic [RUN_W:0]          runs_reg;
    logic [CFG_W-1:0]        a_reg;
    logic [CFG_W:0]          amb_reg;
    logic [39:0]             am_reg;
    logic [24:0]             ab_reg, op_reg;
    logic [40:0]             ep_reg;
    logic [SUM_W-1:0]        end_reg, ed_reg, qlen_reg;
    logic signed [N_W-1:0]   n_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        dvd_reg;
    logic [DEN_W-1:0]        rem_reg, den_reg;
    logic signed [SUM_W-1:0] score_stage_reg;

    // Output registers
    logic [POS_W-1:0]        start_out_reg;
    logic [SUM_W-1:0]        end_out_reg, ed_out_reg, qlen_out_reg;
    logic signed [SUM_W-1:0] score_out_reg;
    logic                    hard_out_reg;

    // Accumulate with saturation
    function automatic logic [SUM_W-1:0] sat_acc(input logic [SUM_W-1:0] acc,
                                                 input logic [LEN_W-1:0] len);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + {{(SUM_W-LEN_W+1){1'b0}}, len};
        return s[SUM_W] ? SAT32 : s[SUM_W-1:0];
    endfunction

    function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] c);
        return (c == MAX_OPS) ? MAX_OPS : c + 1'b1;
    endfunction

    // Combinational helpers
    logic [NM_W-1:0]        gap_diff;
    logic [SUM_W+2:0]       end_sum;
    logic [SUM_W:0]         ed_max;
    logic signed [NUM_W-1:0] n_ext, num_next;
    logic [NUM_W-1:0]       num_neg;
    logic [DEN_W:0]         trial;
    logic [MAG_W:0]         fix_t;

    always_comb
    begin
        gap_diff = ({{(SUM_W+1-NM_W){1'b0}}, nm_reg} > indel_reg)
                   ? (nm_reg - indel_reg[NM_W-1:0]) : '0;
        end_sum  = {4'b0, start_reg} + {1'b0, mds_reg};
        ed_max   = ({{(SUM_W+1-NM_W){1'b0}}, nm_reg} > indel_reg)
                   ? {{(SUM_W+1-NM_W){1'b0}}, nm_reg} : indel_reg;
        n_ext    = NUM_W'(n_reg);
        num_next = (n_ext <<< 10) - (n_ext <<< 4) - (n_ext <<< 3)
                   + $signed(NUM_W'({10'b0, a_reg} * 18'd499));
        num_neg  = -num_reg;
        trial    = {rem_reg, dvd_reg[MAG_W-1]} - {1'b0, den_reg};
        fix_t    = {1'b0, dvd_reg} + {{MAG_W{1'b0}}, (rem_reg != '0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cfg_reg    <= 8'd1;
            b_cfg_reg    <= 8'd4;
            o_cfg_reg    <= 8'd6;
            e_cfg_reg    <= 8'd1;
            match_reg    <= '0;
            ins_reg      <= '0;
            del_reg      <= '0;
            skip_reg     <= '0;
            clip_reg     <= '0;
            ins_runs_reg <= '0;
            del_runs_reg <= '0;
            hard_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_MATCH:    a_cfg_reg <= cfg_data;
                    REG_MISMATCH: b_cfg_reg <= cfg_data;
                    REG_GAP_OPEN: o_cfg_reg <= cfg_data;
                    REG_GAP_EXT:  e_cfg_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.load_out)
            begin
                match_reg    <= '0;
                ins_reg      <= '0;
                del_reg      <= '0;
                skip_reg     <= '0;
                clip_reg     <= '0;
                ins_runs_reg <= '0;
                del_runs_reg <= '0;
                hard_reg     <= 1'b0;
            end
            else if (cmd.acc_en)
            begin
                case (op_code)
                    OP_M: match_reg <= sat_acc(match_reg, op_length);
                    OP_I:
                    begin
                        ins_reg      <= sat_acc(ins_reg, op_length);
                        ins_runs_reg <= run_inc(ins_runs_reg);
                    end
                    OP_D:
                    begin
                        del_reg      <= sat_acc(del_reg, op_length);
                        del_runs_reg <= run_inc(del_runs_reg);
                    end
                    OP_N: skip_reg <= sat_acc(skip_reg, op_length);
                    OP_S: clip_reg <= sat_acc(clip_reg, op_length);
                    OP_H:
                    begin
                        clip_reg <= sat_acc(clip_reg, op_length);
                        hard_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            pos_reg <= ref_position;
            nm_reg  <= nm_tag;
        end
        if (cmd.prep_en)
        begin
            start_reg <= (pos_reg == '0) ? '0 : pos_reg - 1'b1;
            mds_reg   <= {2'b0, match_reg} + {2'b0, del_reg} + {2'b0, skip_reg};
            qsum_reg  <= {2'b0, match_reg} + {2'b0, ins_reg} + {2'b0, clip_reg};
            indel_reg <= {1'b0, del_reg} + {1'b0, ins_reg};
            runs_reg  <= {1'b0, ins_runs_reg} + {1'b0, del_runs_reg};
            a_reg     <= (a_cfg_reg == '0) ? 8'd1 : a_cfg_reg;
            amb_reg   <= ((a_cfg_reg == '0) ? 9'd1 : {1'b0, a_cfg_reg}) + {1'b0, b_cfg_reg};
        end
        if (cmd.mul_en)
        begin
            am_reg   <= {32'b0, a_reg} * {8'b0, match_reg};
            ab_reg   <= {16'b0, amb_reg} * {9'b0, gap_diff};
            op_reg   <= {17'b0, o_cfg_reg} * {8'b0, runs_reg};
            ep_reg   <= {33'b0, e_cfg_reg} * {8'b0, indel_reg};
            end_reg  <= (end_sum[SUM_W+2:SUM_W] != '0) ? SAT32 : end_sum[SUM_W-1:0];
            ed_reg   <= ed_max[SUM_W] ? SAT32 : ed_max[SUM_W-1:0];
            qlen_reg <= (qsum_reg[SUM_W+1:SUM_W] != '0) ? SAT32 : qsum_reg[SUM_W-1:0];
        end
        if (cmd.sum_en)
        begin
            n_reg <= $signed({4'b0, am_reg}) - $signed({19'b0, ab_reg})
                   - $signed({19'b0, op_reg}) - $signed({3'b0, ep_reg});
        end
        if (cmd.scale_en)
            num_reg <= num_next;
        if (cmd.abs_en)
        begin
            neg_reg <= num_reg[NUM_W-1];
            dvd_reg <= num_reg[NUM_W-1] ? num_neg[MAG_W-1:0] : num_reg[MAG_W-1:0];
            rem_reg <= '0;
            den_reg <= DEN_W'({10'b0, a_reg} * 18'd1000);
        end
        if (cmd.div_step)
        begin
            if (!trial[DEN_W])
            begin
                rem_reg <= trial[DEN_W-1:0];
                dvd_reg <= {dvd_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DEN_W-2:0], dvd_reg[MAG_W-1]};
                dvd_reg <= {dvd_reg[MAG_W-2:0], 1'b0};
            end
        end
        if (cmd.fix_en)
        begin
            // floor of a negative quotient drops one more when inexact
            if (neg_reg)
                score_stage_reg <= (fix_t > {{(MAG_W-31){1'b0}}, 32'h8000_0000})
                                   ? 32'sh8000_0000 : $signed(-fix_t[SUM_W-1:0]);
            else
                score_stage_reg <= (dvd_reg > {{(MAG_W-31){1'b0}}, 31'h7FFF_FFFF})
                                   ? 32'sh7FFF_FFFF : $signed(dvd_reg[SUM_W-1:0]);
        end
        if (cmd.load_out)
        begin
            start_out_reg <= start_reg;
            end_out_reg   <= end_reg;
            ed_out_reg    <= ed_reg;
            qlen_out_reg  <= qlen_reg;
            score_out_reg <= score_stage_reg;
            hard_out_reg  <= hard_reg;
        end
    end

    assign ref_start     = start_out_reg;
    assign ref_end       = end_out_reg;
    assign edit_distance = ed_out_reg;
    assign score         = score_out_reg;
    assign query_length  = qlen_out_reg;
    assign hard_clipped  = hard_out_reg;

endmodule

`default_nettype wire

// ===== hdl/cas_checker.sv =====
// Port-level checks for the CIGAR alignment scorer, bound to the top level.
// Depends on cigar_alignment_score ports only.
`default_nettype none

module cas_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        last_op,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] score,
    input wire logic [31:0] ref_end
);

    // A final op closes the input until its result is scored.
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_op) |=> !in_ready)
        else $error("input still open after final op");

    // A non-final op never produces a result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last_op && !out_valid) |=> !out_valid)
        else $error("result without a final op");

    // A new result follows a busy period.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(score) && $stable(ref_end)))
        else $error("stalled result changed");

endmodule

bind cigar_alignment_score cas_checker u_cas_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_op   (last_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .score     (score),
    .ref_end   (ref_end)
);

`default_nettype wire

// ===== tb/cigar_alignment_score_test.sv =====
// Self-checking testbench for cigar_alignment_score: CIGAR op streams in, scores out.
// Depends on cas_pkg and the cigar_alignment_score RTL; carries its own scoring predictor.
`default_nettype none

module cigar_alignment_score_test;
    import cas_pkg::*;

    // Op codes outside the package enum: '=', 'X' and 'P' style ops, ignored by the block
    localparam logic [OP_W-1:0] OP_IGN_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_IGN_HI = 3'd7;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [NM_W-1:0]  NM_MAX  = '1;

    localparam longint SUM_CAP   = 64'd4294967295;
    localparam longint SCORE_MAX = 64'sd2147483647;
    localparam longint SCORE_MIN = -64'sd2147483648;

    localparam int PHASE_ITEMS     = 300;     // minimum count of non-ignored random ops per register setting
    localparam int LONG_HOLD       = 500;     // receiver hold-off for the backpressure test
    localparam int SETTLE_CYCLES   = 80;      // final-op latency plus margin
    localparam int CYCLE_LIMIT     = 1500000;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [SUM_W-1:0] stop;
        logic [SUM_W-1:0] edit;
        logic [SUM_W-1:0] score;
        logic [SUM_W-1:0] qlen;
        logic             hard;
    } alignment_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   code;
        logic [LEN_W-1:0]  len;
        logic [POS_W-1:0]  pos;
        logic [NM_W-1:0]   nm;
        logic              last;
        logic              typed;   // use the expectation written in the table
        alignment_result_t want;
    } cigar_row_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op_code      = '0;
    logic [LEN_W-1:0]   op_length    = '0;
    logic [POS_W-1:0]   ref_position = '0;
    logic [NM_W-1:0]    nm_tag       = '0;
    logic               last_op      = 1'b0;

    logic                    out_valid;
    logic                    out_ready = 1'b1;
    logic [POS_W-1:0]        ref_start;
    logic [SUM_W-1:0]        ref_end;
    logic [SUM_W-1:0]        edit_distance;
    logic signed [SUM_W-1:0] score;
    logic [SUM_W-1:0]        query_length;
    logic                    hard_clipped;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    cigar_alignment_score dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op_code       (op_code),
        .op_length     (op_length),
        .ref_position  (ref_position),
        .nm_tag        (nm_tag),
        .last_op       (last_op),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ref_start     (ref_start),
        .ref_end       (ref_end),
        .edit_distance (edit_distance),
        .score         (score),
        .query_length  (query_length),
        .hard_clipped  (hard_clipped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int cycles = 0;

    // Abort a hung run; the limit covers the slowest legal schedule several times over
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Scoring predictor: its own copy of the registers and accumulators
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] w_match      = 8'd1;
    logic [CFG_W-1:0] w_mismatch   = 8'd4;
    logic [CFG_W-1:0] w_gap_open   = 8'd6;
    logic [CFG_W-1:0] w_gap_extend = 8'd1;

    logic [SUM_W-1:0] acc_match = '0;
    logic [SUM_W-1:0] acc_ins   = '0;
    logic [SUM_W-1:0] acc_del   = '0;
    logic [SUM_W-1:0] acc_skip  = '0;
    logic [SUM_W-1:0] acc_clip  = '0;
    logic [RUN_W-1:0] ins_runs  = '0;
    logic [RUN_W-1:0] del_runs  = '0;
    logic             saw_hard  = 1'b0;

    // Results owed by the block, oldest first
    alignment_result_t awaited[$];

    int  failures        = 0;
    int  ops_sent        = 0;
    int  counted_ops     = 0;
    int  results_checked = 0;
    int  settings_loaded = 1;    // the reset values count as one
    bit  gaps_on         = 1'b1;
    bit  stalls_on       = 1'b1;
    bit  hold_req        = 1'b0;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [LEN_W-1:0] len);
        logic [SUM_W:0] wide;
        wide = {1'b0, acc} + {5'b0, len};
        return wide[SUM_W] ? SAT32 : wide[SUM_W-1:0];
    endfunction

    // Fold one op into the accumulators; on the final op produce the scored alignment
    task automatic tally_op(input cigar_row_t row, output bit emits,
                            output alignment_result_t res);
        logic [POS_W-1:0] start;
        longint a, b, o, e, runs, m, indel, ed, span, n, num, den, q;
        res   = '0;
        emits = 1'b0;
        case (row.code)
            OP_M: acc_match = sat_add(acc_match, row.len);
            OP_I:
            begin
                acc_ins  = sat_add(acc_ins, row.len);
                ins_runs = (ins_runs == MAX_OPS) ? ins_runs : ins_runs + 1'b1;
            end
            OP_D:
            begin
                acc_del  = sat_add(acc_del, row.len);
                del_runs = (del_runs == MAX_OPS) ? del_runs : del_runs + 1'b1;
            end
            OP_N: acc_skip = sat_add(acc_skip, row.len);
            OP_S: acc_clip = sat_add(acc_clip, row.len);
            OP_H:
            begin
                acc_clip = sat_add(acc_clip, row.len);
                saw_hard = 1'b1;
            end
            default: ;
        endcase
        if (!row.last)
            return;

        emits = 1'b1;
        start = (row.pos == '0) ? '0 : row.pos - 1'b1;
        m     = acc_match;
        indel = longint'(acc_del) + longint'(acc_ins);
        ed    = (longint'(row.nm) > indel) ? longint'(row.nm) : indel;
        span  = longint'(start) + m + longint'(acc_del) + longint'(acc_skip);

        res.start = start;
        res.stop  = (span > SUM_CAP) ? SAT32 : span[SUM_W-1:0];
        res.edit  = (ed > SUM_CAP) ? SAT32 : ed[SUM_W-1:0];
        span      = m + longint'(acc_ins) + longint'(acc_clip);
        res.qlen  = (span > SUM_CAP) ? SAT32 : span[SUM_W-1:0];
        res.hard  = saw_hard;

        // 0.499 rounding as 499/1000, floor division, then clamp to 32-bit signed
        a    = (w_match == '0) ? 1 : longint'(w_match);
        b    = w_mismatch;
        o    = w_gap_open;
        e    = w_gap_extend;
        runs = longint'(ins_runs) + longint'(del_runs);
        n    = a * m - (a + b) * (ed - indel) - o * runs - e * indel;
        num  = 1000 * n + 499 * a;
        den  = 1000 * a;
        q    = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        if (q > SCORE_MAX)
            q = SCORE_MAX;
        if (q < SCORE_MIN)
            q = SCORE_MIN;
        res.score = q[SUM_W-1:0];

        acc_match = '0;
        acc_ins   = '0;
        acc_del   = '0;
        acc_skip  = '0;
        acc_clip  = '0;
        ins_runs  = '0;
        del_runs  = '0;
        saw_hard  = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Op channel driver
    // ------------------------------------------------------------------
    // Offer one op, hold it until the transaction completes, then predict.
    // Valid stays high across back-to-back ops; it only drops for a gap.
    task automatic send_op(input cigar_row_t row);
        alignment_result_t predicted;
        bit emits;
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op_code      <= row.code;
        op_length    <= row.len;
        ref_position <= row.pos;
        nm_tag       <= row.nm;
        last_op      <= row.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tally_op(row, emits, predicted);
        if (emits)
            awaited.insert(awaited.size(), row.typed ? row.want : predicted);
        ops_sent++;
        if (row.code <= OP_H)
            counted_ops++;
    endtask

    // Drop valid, let every owed result drain, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Register channel driver
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MATCH:    w_match      = val;
            REG_MISMATCH: w_mismatch   = val;
            REG_GAP_OPEN: w_gap_open   = val;
            REG_GAP_EXT:  w_gap_extend = val;
            default: ;
        endcase
    endtask

    // Load a full register setting while the block is idle; also poke an unmapped index
    task automatic load_settings(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b,
                                 input logic [CFG_W-1:0] o, input logic [CFG_W-1:0] e);
        wait_idle();
        write_reg(REG_MATCH, a);
        write_reg(REG_MISMATCH, b);
        write_reg(REG_GAP_OPEN, o);
        write_reg(REG_GAP_EXT, e);
        write_reg(settings_loaded[0] ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, $urandom);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    cigar_row_t directed_rows[$];

    // Row checked against the predictor
    task automatic add_row(input logic [OP_W-1:0] code, input logic [LEN_W-1:0] len,
                           input logic [POS_W-1:0] pos, input logic [NM_W-1:0] nm,
                           input logic last);
        cigar_row_t row;
        row      = '0;
        row.code = code;
        row.len  = len;
        row.pos  = pos;
        row.nm   = nm;
        row.last = last;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Final op with its result written out by hand
    task automatic add_checked_row(input logic [OP_W-1:0] code, input logic [LEN_W-1:0] len,
                                   input logic [POS_W-1:0] pos, input logic [NM_W-1:0] nm,
                                   input logic [POS_W-1:0] start, input logic [SUM_W-1:0] stop,
                                   input logic [SUM_W-1:0] edit, input logic [SUM_W-1:0] sc,
                                   input logic [SUM_W-1:0] qlen, input logic hard);
        cigar_row_t row;
        row            = '0;
        row.code       = code;
        row.len        = len;
        row.pos        = pos;
        row.nm         = nm;
        row.last       = 1'b1;
        row.typed      = 1'b1;
        row.want.start = start;
        row.want.stop  = stop;
        row.want.edit  = edit;
        row.want.score = sc;
        row.want.qlen  = qlen;
        row.want.hard  = hard;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // ------------------------------------------------------------------
    // Random alignments
    // ------------------------------------------------------------------
    function automatic logic [OP_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7)  return OP_M;
        if (r < 10) return OP_I;
        if (r < 13) return OP_D;
        if (r < 14) return OP_N;
        if (r < 16) return OP_S;
        if (r < 18) return OP_H;
        return r[0] ? OP_IGN_HI : OP_IGN_LO;
    endfunction

    task automatic send_random_alignment();
        cigar_row_t       row;
        int               kind, n_ops;
        logic [OP_W-1:0]  solo_code;
        logic [POS_W-1:0] pos;
        logic [NM_W-1:0]  nm;
        // kind 0: one op type at near-max lengths, which nearly always saturates that sum
        // kind 1: long mixed alignment of large ops
        // kind 2..4: noise, any code and any length
        // otherwise: short well-formed alignment
        kind      = $urandom_range(0, 19);
        solo_code = $urandom_range(0, 5);
        case (kind)
            0:       n_ops = $urandom_range(17, 24);
            1:       n_ops = $urandom_range(24, 60);
            default: n_ops = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 7))
            0:       pos = '0;
            1:       pos = POS_MAX;
            2:       pos = 31'd1;
            default: pos = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       nm = '0;
            1:       nm = NM_MAX;
            2:       nm = $urandom;
            default: nm = $urandom_range(0, 40);
        endcase
        for (int i = 0; i < n_ops; i++)
        begin
            row = '0;
            if (kind == 0)
            begin
                row.code = solo_code;
                row.len  = $urandom_range(LEN_MAX - 28'h0FF_FFFF, LEN_MAX);
            end
            else if (kind == 1)
            begin
                row.code = pick_code();
                row.len  = $urandom_range(LEN_MAX / 2, LEN_MAX);
            end
            else if (kind < 5)
            begin
                row.code = $urandom_range(0, 7);
                row.len  = $urandom;
            end
            else
            begin
                row.code = pick_code();
                case ($urandom_range(0, 9))
                    0:       row.len = '0;
                    1:       row.len = LEN_MAX;
                    2:       row.len = $urandom;
                    default: row.len = $urandom_range(1, 300);
                endcase
            end
            row.last = (i == n_ops - 1);
            // position and NM only matter on the final op; vary them elsewhere
            row.pos  = row.last ? pos : $urandom;
            row.nm   = row.last ? nm : $urandom;
            send_op(row);
        end
    endtask

    // ------------------------------------------------------------------
    // Result monitor and receiver
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    // Sample each transaction at the edge, compare it with the oldest expectation,
    // then decide ready for the next cycle. Stalls only count down while a result
    // is waiting, so they land on live results.
    initial
    begin : result_sink
        alignment_result_t want;
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result with no alignment pending: ref_start %0d", ref_start);
                    failures++;
                end
                else
                begin
                    want = awaited.pop_front();
                    check_field("ref_start", longint'(want.start), longint'(ref_start));
                    check_field("ref_end", longint'(want.stop), longint'(ref_end));
                    check_field("edit_distance", longint'(want.edit),
                                longint'(edit_distance));
                    check_field("score", longint'($signed(want.score)), longint'(score));
                    check_field("query_length", longint'(want.qlen),
                                longint'(query_length));
                    check_field("hard_clipped", longint'(want.hard),
                                longint'(hard_clipped));
                    results_checked++;
                end
                stall_left = stalls_on ? $urandom_range(0, 4) : 0;
            end
            else if (out_valid && stall_left > 0)
                stall_left--;
            // one long hold-off, counted here, while the sender keeps pushing
            if (hold_req && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            else if (hold_left > 0)
                hold_left--;
            out_ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset register values (a 1, b 4, o 6, e 1)
        add_checked_row(OP_M, 28'd10, 31'd1, 16'd0,
                        31'd0, 32'd10, 32'd0, 32'd10, 32'd10, 1'b0);
        // ignored op alone ends an empty alignment; position zero stays zero
        add_checked_row(OP_IGN_LO, 28'd0, 31'd0, 16'd0,
                        31'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        // all fields at their maximum: NM sets the edit distance
        add_checked_row(OP_M, LEN_MAX, POS_MAX, NM_MAX,
                        31'd2147483646, 32'd2415919101, 32'd65535, 32'd268107780,
                        32'd268435455, 1'b0);
        // zero-length indels still open runs; hard clip sets the flag
        add_row(OP_I, 28'd0, 31'd0, 16'd0, 1'b0);
        add_row(OP_D, 28'd0, 31'd0, 16'd0, 1'b0);
        add_checked_row(OP_H, 28'd5, 31'd1, 16'd0,
                        31'd0, 32'd0, 32'd0, -32'sd12, 32'd5, 1'b1);
        // an ordinary spliced read with soft clips
        add_row(OP_S, 28'd3, 31'd0, 16'd0, 1'b0);
        add_row(OP_M, 28'd50, 31'd0, 16'd0, 1'b0);
        add_row(OP_I, 28'd2, 31'd0, 16'd0, 1'b0);
        add_row(OP_M, 28'd20, 31'd0, 16'd0, 1'b0);
        add_row(OP_D, 28'd4, 31'd0, 16'd0, 1'b0);
        add_row(OP_M, 28'd30, 31'd0, 16'd0, 1'b0);
        add_row(OP_N, 28'd1000, 31'd0, 16'd0, 1'b0);
        add_row(OP_M, 28'd10, 31'd0, 16'd0, 1'b0);
        add_row(OP_S, 28'd7, 31'd100, 16'd3, 1'b1);
        // H, N, I, D and an ignored op at full length, then a one-length M ends it
        add_row(OP_H, LEN_MAX, 31'd0, 16'd0, 1'b0);
        add_row(OP_N, LEN_MAX, 31'd0, 16'd0, 1'b0);
        add_row(OP_I, LEN_MAX, 31'd0, 16'd0, 1'b0);
        add_row(OP_D, LEN_MAX, 31'd0, 16'd0, 1'b0);
        add_row(OP_IGN_HI, LEN_MAX, 31'd0, 16'd0, 1'b0);
        add_row(OP_M, 28'd1, POS_MAX, 16'd0, 1'b1);
        add_row(OP_IGN_LO, 28'd5, 31'd2, 16'd1, 1'b1);
        add_row(OP_M, 28'd0, 31'd1, NM_MAX, 1'b1);
        foreach (directed_rows[i])
            send_op(directed_rows[i]);
        wait_idle();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:       load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2:       load_settings(8'd0, $urandom, $urandom, $urandom);
                3:       load_settings(8'd1, 8'd0, 8'd0, 8'd0);
                default: load_settings($urandom, $urandom, $urandom, $urandom);
            endcase
            gaps_on   = (phase != 2) && (phase != 4);
            stalls_on = (phase != 4);
            // fill the block while the receiver holds off
            if (phase == 2)
                hold_req = 1'b1;
            counted_ops = 0;
            while (counted_ops < PHASE_ITEMS)
                send_random_alignment();
        end
        wait_idle();

        $display("%0d CIGAR ops accepted, %0d alignments scored and checked",
                 ops_sent, results_checked);
        $display("%0d register settings, saturated length sums, one long stall",
                 settings_loaded);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
